// File: hw/rtl/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

	// Number of matrix elements and quotient bits produced by the divider.
	localparam int NumEl    = 9;
	localparam int DivSteps = 33;
	localparam int DenW     = 50;
	localparam int QuotW    = DivSteps;

	// Saturation limits of a Q15.16 result.
	localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
	localparam logic [31:0] SatNeg = 32'h8000_0000;

	// One inverse element in flight through the long division.
	typedef struct packed {
		logic [DenW-1:0]  rem;
		logic [QuotW-1:0] low;
		logic             neg;
		logic             ovf;
	} lane_t;

	// Everything one request carries through the division pipeline.
	typedef struct packed {
		lane_t [NumEl-1:0] lane;
		logic [DenW-1:0]   den;
		logic [31:0]       detq;
		logic              singular;
	} pl_t;

	// One restoring division step on every lane: bring in the next numerator bit,
	// subtract the divisor when it fits and shift the quotient bit in at the bottom.
	function automatic pl_t div_step(input pl_t p);
		pl_t           r;
		logic [DenW:0] t;
		logic          ge;
		r = p;
		for (int k = 0; k < NumEl; k++) begin
			t  = {p.lane[k].rem, p.lane[k].low[QuotW-1]};
			ge = (t >= {1'b0, p.den});
			r.lane[k].rem = ge ? DenW'(t - {1'b0, p.den}) : t[DenW-1:0];
			r.lane[k].low = {p.lane[k].low[QuotW-2:0], ge};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/m3i_in_if.sv
`default_nettype none
interface m3i_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] a00;
	logic signed [15:0] a01;
	logic signed [15:0] a02;
	logic signed [15:0] a10;
	logic signed [15:0] a11;
	logic signed [15:0] a12;
	logic signed [15:0] a20;
	logic signed [15:0] a21;
	logic signed [15:0] a22;

	modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
	modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/m3i_out_if.sv
`default_nettype none
interface m3i_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] inv00;
	logic signed [31:0] inv01;
	logic signed [31:0] inv02;
	logic signed [31:0] inv10;
	logic signed [31:0] inv11;
	logic signed [31:0] inv12;
	logic signed [31:0] inv20;
	logic signed [31:0] inv21;
	logic signed [31:0] inv22;
	logic signed [31:0] det_value;
	logic               singular;

	modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
		inv22, det_value, singular, input ready);
	modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
		inv22, det_value, singular, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/m3i_div_step.sv
`default_nettype none
module m3i_div_step (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire m3i_pkg::pl_t in_pl,
	output logic              in_ready,
	output logic              out_valid,
	output m3i_pkg::pl_t      out_pl,
	input  wire logic         out_ready
);
	import m3i_pkg::*;

	logic valid_s1;
	pl_t  pl_s1;
	logic en;

	// The stage advances when it is empty or its result moves on.
	assign en       = !valid_s1 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// One quotient bit for all nine lanes.
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			pl_s1 <= div_step(in_pl);
		end
	end

	assign out_valid = valid_s1;
	assign out_pl    = pl_s1;
endmodule
`default_nettype wire

// File: hw/rtl/matrix3x3_inverse.sv
// Throughput: one matrix per cycle while the output is not stalled; every stage holds one request.
// The depth comes from the 33-step restoring division, one quotient bit per stage.
// A stalled output backs up stage by stage; empty stages still fill.
// Reset clears all valid bits asynchronously; data registers are not reset.
`default_nettype none
module matrix3x3_inverse (
	input wire logic clk,
	input wire logic arst_n,
	m3i_in_if.sink   mat,
	m3i_out_if.source inv
);
	import m3i_pkg::*;

	// Stage 1: the eighteen 2x2 minor products.
	logic                     valid_s1;
	logic signed [17:0][31:0] prod_s1;
	logic signed [2:0][15:0]  row_s1;
	// Stage 2: the adjugate.
	logic                     valid_s2;
	logic signed [8:0][32:0]  adj_s2;
	logic signed [2:0][15:0]  row_s2;
	// Stage 3: first-row terms of the determinant.
	logic                     valid_s3;
	logic signed [8:0][32:0]  adj_s3;
	logic signed [2:0][48:0]  term_s3;
	// Stage 4: the determinant.
	logic                     valid_s4;
	logic signed [8:0][32:0]  adj_s4;
	logic signed [49:0]       det_s4;
	// Stage 5: division operands.
	logic                     valid_s5;
	pl_t                      pl_s5;

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_o;
	logic [DivSteps:0] v_c;
	logic [DivSteps:0] r_c;
	pl_t  pl_c [DivSteps+1];

	// Output register.
	logic        valid_q;
	logic [31:0] res_q [NumEl];
	logic [31:0] detq_q;
	logic        sing_q;

	// Backpressure: each stage moves when empty or when the next one takes its data.
	assign en_o  = !valid_q || inv.ready;
	assign en_s5 = !valid_s5 || r_c[0];
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign mat.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= mat.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_o)  valid_q  <= v_c[DivSteps];
		end
	end

	// Minor products, ordered so that adjugate entry k is prod[2k] - prod[2k+1].
	always_ff @(posedge clk) begin
		if (en_s1 && mat.valid) begin
			prod_s1[0]  <= 32'(mat.a11) * 32'(mat.a22);
			prod_s1[1]  <= 32'(mat.a12) * 32'(mat.a21);
			prod_s1[2]  <= 32'(mat.a02) * 32'(mat.a21);
			prod_s1[3]  <= 32'(mat.a01) * 32'(mat.a22);
			prod_s1[4]  <= 32'(mat.a01) * 32'(mat.a12);
			prod_s1[5]  <= 32'(mat.a02) * 32'(mat.a11);
			prod_s1[6]  <= 32'(mat.a12) * 32'(mat.a20);
			prod_s1[7]  <= 32'(mat.a10) * 32'(mat.a22);
			prod_s1[8]  <= 32'(mat.a00) * 32'(mat.a22);
			prod_s1[9]  <= 32'(mat.a02) * 32'(mat.a20);
			prod_s1[10] <= 32'(mat.a02) * 32'(mat.a10);
			prod_s1[11] <= 32'(mat.a00) * 32'(mat.a12);
			prod_s1[12] <= 32'(mat.a10) * 32'(mat.a21);
			prod_s1[13] <= 32'(mat.a11) * 32'(mat.a20);
			prod_s1[14] <= 32'(mat.a01) * 32'(mat.a20);
			prod_s1[15] <= 32'(mat.a00) * 32'(mat.a21);
			prod_s1[16] <= 32'(mat.a00) * 32'(mat.a11);
			prod_s1[17] <= 32'(mat.a01) * 32'(mat.a10);
			row_s1[0]   <= mat.a00;
			row_s1[1]   <= mat.a01;
			row_s1[2]   <= mat.a02;
		end
	end

	// Adjugate as differences of minor products.
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			for (int k = 0; k < NumEl; k++) begin
				adj_s2[k] <= 33'(signed'(prod_s1[2*k])) - 33'(signed'(prod_s1[2*k+1]));
			end
			row_s2 <= row_s1;
		end
	end

	// Expansion along the first row.
	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			term_s3[0] <= 49'(signed'(row_s2[0])) * 49'(signed'(adj_s2[0]));
			term_s3[1] <= 49'(signed'(row_s2[1])) * 49'(signed'(adj_s2[3]));
			term_s3[2] <= 49'(signed'(row_s2[2])) * 49'(signed'(adj_s2[6]));
			adj_s3     <= adj_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			det_s4 <= 50'(signed'(term_s3[0])) + 50'(signed'(term_s3[1]))
				+ 50'(signed'(term_s3[2]));
			adj_s4 <= adj_s3;
		end
	end

	// Division setup: numerator 2*|cof|*2^28 + |det|, divisor 2*|det|.
	// The top numerator bits form the first remainder; if they already reach
	// the divisor, the quotient is at least 2^33 and saturates.
	pl_t                pl_d;
	logic        [48:0] dabs;
	logic signed [50:0] drnd;
	always_comb begin
		logic [31:0] cabs;
		logic [60:0] num;
		dabs = det_s4[49] ? 49'(-det_s4) : det_s4[48:0];
		drnd = 51'(signed'(det_s4)) + 51'(24'h80_0000);
		pl_d.den      = {dabs, 1'b0};
		pl_d.detq     = 32'(drnd >>> 24);
		pl_d.singular = (det_s4 == '0);
		for (int k = 0; k < NumEl; k++) begin
			cabs = adj_s4[k][32] ? 32'(-adj_s4[k]) : adj_s4[k][31:0];
			num  = {cabs, 29'd0} + 61'(dabs);
			pl_d.lane[k].rem = DenW'(num[60:33]);
			pl_d.lane[k].low = num[32:0];
			pl_d.lane[k].neg = adj_s4[k][32] ^ det_s4[49];
			pl_d.lane[k].ovf = ({22'd0, num[60:33]} >= pl_d.den);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && valid_s4) begin
			pl_s5 <= pl_d;
		end
	end

	// Long division, one quotient bit per stage.
	assign v_c[0]        = valid_s5;
	assign pl_c[0]       = pl_s5;
	assign r_c[DivSteps] = en_o;

	for (genvar g = 0; g < DivSteps; g++) begin : g_div
		m3i_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[g]),
			.in_pl     (pl_c[g]),
			.in_ready  (r_c[g]),
			.out_valid (v_c[g+1]),
			.out_pl    (pl_c[g+1]),
			.out_ready (r_c[g+1])
		);
	end

	// Sign, saturation and the singular case.
	pl_t pl_f;
	assign pl_f = pl_c[DivSteps];
	always_ff @(posedge clk) begin
		if (en_o && v_c[DivSteps]) begin
			for (int k = 0; k < NumEl; k++) begin
				if (pl_f.singular) begin
					res_q[k] <= '0;
				end else if (pl_f.lane[k].neg) begin
					if (pl_f.lane[k].ovf || pl_f.lane[k].low > {1'b0, SatNeg}) begin
						res_q[k] <= SatNeg;
					end else begin
						res_q[k] <= 32'(-pl_f.lane[k].low);
					end
				end else begin
					if (pl_f.lane[k].ovf || pl_f.lane[k].low[32:31] != 2'b00) begin
						res_q[k] <= SatPos;
					end else begin
						res_q[k] <= pl_f.lane[k].low[31:0];
					end
				end
			end
			detq_q <= pl_f.singular ? '0 : pl_f.detq;
			sing_q <= pl_f.singular;
		end
	end

	assign inv.valid     = valid_q;
	assign inv.inv00     = res_q[0];
	assign inv.inv01     = res_q[1];
	assign inv.inv02     = res_q[2];
	assign inv.inv10     = res_q[3];
	assign inv.inv11     = res_q[4];
	assign inv.inv12     = res_q[5];
	assign inv.inv20     = res_q[6];
	assign inv.inv21     = res_q[7];
	assign inv.inv22     = res_q[8];
	assign inv.det_value = detq_q;
	assign inv.singular  = sing_q;

	// A singular result carries zeros in det_value, inv00 and inv11.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && sing_q |-> detq_q == '0 && res_q[0] == '0 && res_q[4] == '0)
		else $error("singular result with nonzero data");

	// The singular flag follows a zero divisor.
	a_sing_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> pl_s5.singular == (pl_s5.den == '0))
		else $error("singular flag and divisor disagree");

	// A held output keeps the last division stage full.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_c[DivSteps] && !en_o |=> v_c[DivSteps])
		else $error("division result lost under stall");
endmodule
`default_nettype wire
